// File: src/grpp_pkg.sv
// ----------------------------------------------------------------------------
// grpp_pkg
// Shared constants, types and helpers for the glyph row pixel packer.
// ----------------------------------------------------------------------------
`default_nettype none

package grpp_pkg;

   localparam int GLYPH_WIDTH   = 8;
   localparam int UNDERLINE_ROW = 15;
   localparam int STRIKE_ROW    = 8;
   localparam int MAX_WORDS     = 33;
   localparam int QUEUE_DEPTH   = 2;
   localparam int MAX_HSCALE    = 4;

   // Replicated row: every glyph pixel repeated up to MAX_HSCALE times.
   localparam int REP_W      = GLYPH_WIDTH * MAX_HSCALE;
   // Slot stream: replicated row plus room for a leading pixel offset.
   localparam int STREAM_W   = REP_W + 32;
   localparam int NPIX_W     = $clog2(REP_W + 1);
   localparam int WORD_CNT_W = $clog2(MAX_WORDS + 1);

   // Text attribute bit positions
   localparam int BOLD_BIT        = 0;
   localparam int INVERSE_BIT     = 1;
   localparam int UNDERLINE_BIT   = 2;
   localparam int STRIKE_BIT      = 3;
   localparam int TRANSPARENT_BIT = 4;
   localparam int HSCALE_LSB      = 5;

   typedef enum logic [2:0] {
      CSR_PIXEL_SIZE_LOG2 = 3'd0,
      CSR_FOREGROUND      = 3'd1,
      CSR_BACKGROUND      = 3'd2,
      CSR_LINE_PITCH      = 3'd3,
      CSR_FRAME_BASE      = 3'd4,
      CSR_TEXT_ATTR       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  pixel_size_log2;
      logic [31:0] foreground_color;
      logic [31:0] background_color;
      logic [15:0] line_pitch;
      logic [31:0] frame_base;
      logic [6:0]  text_attributes;
   } cfg_type;

   // One classified glyph row, ready to be packed into words.
   typedef struct packed {
      logic [REP_W-1:0]      rep;
      logic [NPIX_W-1:0]     npix;
      logic [4:0]            off_pix;
      logic [WORD_CNT_W-1:0] word_count;
      logic [31:0]           base;
   } desc_type;

   // Saturate the pixel size code to 32 bpp.
   function automatic logic [2:0] sat_lg(input logic [2:0] code);
      sat_lg = (code > 3'd5) ? 3'd5 : code;
   endfunction

endpackage

`default_nettype wire

// File: src/glyph_row_pixel_packer.sv
// ----------------------------------------------------------------------------
// glyph_row_pixel_packer
// Turns one bitmap font glyph row into masked 32-bit framebuffer word writes.
// ----------------------------------------------------------------------------
// A row transaction (font bits, row number, pixel x, line y) is shaped by the
// text attributes (bold, underline, strike, inverse), each pixel repeated
// 1 to 4 times and packed from the most significant end of each word at
// 1 to 32 bits per pixel. Every touched word comes out as one transaction
// with its byte address, data and a bit mask; last_word marks the final
// word of the row. The front side classifies a row combinationally and parks
// it in a short descriptor queue, so req_full only rises when the queue is
// full. The back side loads a descriptor and then emits one word per cycle
// while its result is taken, so a row is a load step and nwords words, where
// nwords = ceil((x_pixel*bpp mod 32 + 8*hscale*bpp) / 32). With hscale 1
// that is 1 or 2 words at 1 to 4 bpp and 8 words at 32 bpp; the widest
// row is 32 words at 32 bpp with hscale 4. A stalled result
// holds the emitter. The word emitter sets the sustained rate. Write
// configuration registers only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_row_pixel_packer #(
   parameter int QUEUE_DEPTH = grpp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // configuration write port
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   // row transactions in
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_glyph_bits,
   input  logic [3:0]  req_glyph_row,
   input  logic [11:0] req_x_pixel,
   input  logic [11:0] req_y_line,
   // word transactions out
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_word_address,
   output logic [31:0] rsp_word_data,
   output logic [31:0] rsp_bit_mask,
   output logic        rsp_last_word
);
   import grpp_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   desc_type front_desc;
   desc_type q_desc;
   logic     q_full, q_empty, q_pop;

   // Configuration registers: decode the index, drop writes beyond the list.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PIXEL_SIZE_LOG2: cfg_in.pixel_size_log2  = csr_wdata[2:0];
            CSR_FOREGROUND:      cfg_in.foreground_color = csr_wdata;
            CSR_BACKGROUND:      cfg_in.background_color = csr_wdata;
            CSR_LINE_PITCH:      cfg_in.line_pitch       = csr_wdata[15:0];
            CSR_FRAME_BASE:      cfg_in.frame_base       = csr_wdata;
            CSR_TEXT_ATTR:       cfg_in.text_attributes  = csr_wdata[6:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: classify the row and compute its word span.
   grpp_front u_front (
      .cfg        (cfg_ff),
      .glyph_bits (req_glyph_bits),
      .glyph_row  (req_glyph_row),
      .x_pixel    (req_x_pixel),
      .y_line     (req_y_line),
      .desc       (front_desc)
   );

   // Hold classified rows until the back side is free.
   grpp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_desc (front_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_desc  (q_desc),
      .empty     (q_empty)
   );

   assign req_full = q_full;

   // Back: advance one word per cycle into the output register unless it stalls.
   grpp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_desc           (q_desc),
      .q_pop            (q_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_word_address (rsp_word_address),
      .rsp_word_data    (rsp_word_data),
      .rsp_bit_mask     (rsp_bit_mask),
      .rsp_last_word    (rsp_last_word)
   );

endmodule

`default_nettype wire

// File: src/grpp_front.sv
// ----------------------------------------------------------------------------
// grpp_front
// Shapes the glyph row by its attributes, replicates pixels horizontally and
// works out the start address, pixel offset and word count of the row.
// ----------------------------------------------------------------------------
`default_nettype none

module grpp_front (
   input  grpp_pkg::cfg_type  cfg,
   input  logic [7:0]         glyph_bits,
   input  logic [3:0]         glyph_row,
   input  logic [11:0]        x_pixel,
   input  logic [11:0]        y_line,
   output grpp_pkg::desc_type desc
);
   import grpp_pkg::*;

   localparam int TOTAL_W = $clog2(31 + REP_W * 32 + 31 + 1);
   localparam int NW_W    = TOTAL_W - 5;

   logic [2:0]             lg;
   logic [1:0]             hm1;
   logic                   fill_row;
   logic [GLYPH_WIDTH-1:0] fd;
   logic [REP_W-1:0]       rep;
   logic [NPIX_W-1:0]      npix;
   logic [16:0]            xbits;
   logic [4:0]             off_pix;
   logic [4:0]             off_bits;
   logic [TOTAL_W-1:0]     total;
   logic [NW_W-1:0]        nwords_raw;
   logic [27:0]            line_offset;

   assign lg  = sat_lg(cfg.pixel_size_log2);
   assign hm1 = cfg.text_attributes[HSCALE_LSB +: 2];

   assign fill_row =
      (cfg.text_attributes[UNDERLINE_BIT] && ({1'b0, glyph_row} == 5'(UNDERLINE_ROW))) ||
      (cfg.text_attributes[STRIKE_BIT] && ({1'b0, glyph_row} == 5'(STRIKE_ROW)));

   always_comb begin
      if (fill_row) begin
         fd = '1;
      end else begin
         fd = GLYPH_WIDTH'(glyph_bits);
         if (cfg.text_attributes[BOLD_BIT]) begin
            fd = fd | (fd >> 1);
         end
      end
      if (cfg.text_attributes[INVERSE_BIT]) begin
         fd = ~fd;
      end
   end

   // Horizontal replication: slot i shows glyph column i / hscale.
   for (genvar i = 0; i < REP_W; i++) begin : g_rep
      localparam int C1 = i;
      localparam int C2 = i / 2;
      localparam int C3 = i / 3;
      localparam int C4 = i / 4;
      localparam bit IN1 = C1 < GLYPH_WIDTH;
      localparam bit IN2 = C2 < GLYPH_WIDTH;
      localparam bit IN3 = C3 < GLYPH_WIDTH;
      localparam bit IN4 = C4 < GLYPH_WIDTH;
      localparam int I1 = IN1 ? GLYPH_WIDTH - 1 - C1 : 0;
      localparam int I2 = IN2 ? GLYPH_WIDTH - 1 - C2 : 0;
      localparam int I3 = IN3 ? GLYPH_WIDTH - 1 - C3 : 0;
      localparam int I4 = IN4 ? GLYPH_WIDTH - 1 - C4 : 0;
      always_comb begin
         case (hm1)
            2'd0:    rep[REP_W-1-i] = IN1 ? fd[I1] : 1'b0;
            2'd1:    rep[REP_W-1-i] = IN2 ? fd[I2] : 1'b0;
            2'd2:    rep[REP_W-1-i] = IN3 ? fd[I3] : 1'b0;
            default: rep[REP_W-1-i] = IN4 ? fd[I4] : 1'b0;
         endcase
      end
   end

   always_comb begin
      case (hm1)
         2'd0:    npix = NPIX_W'(GLYPH_WIDTH);
         2'd1:    npix = NPIX_W'(GLYPH_WIDTH * 2);
         2'd2:    npix = NPIX_W'(GLYPH_WIDTH * 3);
         default: npix = NPIX_W'(GLYPH_WIDTH * 4);
      endcase
   end

   assign xbits    = {5'b0, x_pixel} << lg;
   assign off_pix  = x_pixel[4:0] & (5'd31 >> lg);
   assign off_bits = xbits[4:0];
   assign total    = TOTAL_W'(off_bits) + (TOTAL_W'(npix) << lg) + TOTAL_W'(31);
   assign nwords_raw = total[TOTAL_W-1:5];

   assign line_offset = 28'(cfg.line_pitch) * 28'(y_line);

   always_comb begin
      desc.rep     = rep;
      desc.npix    = npix;
      desc.off_pix = off_pix;
      desc.base    = cfg.frame_base + 32'(line_offset) + {18'b0, xbits[16:5], 2'b00};
      if (nwords_raw > NW_W'(MAX_WORDS)) begin
         desc.word_count = WORD_CNT_W'(MAX_WORDS);
      end else begin
         desc.word_count = WORD_CNT_W'(nwords_raw);
      end
   end

endmodule

`default_nettype wire

// File: src/grpp_queue.sv
// ----------------------------------------------------------------------------
// grpp_queue
// Short first-in first-out queue of row descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module grpp_queue #(
   parameter int DEPTH = grpp_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  grpp_pkg::desc_type push_desc,
   output logic               full,
   input  logic               pop,
   output grpp_pkg::desc_type pop_desc,
   output logic               empty
);
   import grpp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

// File: src/grpp_back.sv
// ----------------------------------------------------------------------------
// grpp_back
// Walks a row descriptor: takes one word of pixel slots from the slot stream
// per cycle unless the output stalls, and expands it into data and mask bits.
// ----------------------------------------------------------------------------
`default_nettype none

module grpp_back (
   input  logic               clock,
   input  logic               reset,
   input  grpp_pkg::cfg_type  cfg,
   input  logic               q_empty,
   input  grpp_pkg::desc_type q_desc,
   output logic               q_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [31:0]        rsp_word_address,
   output logic [31:0]        rsp_word_data,
   output logic [31:0]        rsp_bit_mask,
   output logic               rsp_last_word
);
   import grpp_pkg::*;

   logic                  active_ff, active_in;
   logic                  out_valid_ff, out_valid_in;
   logic [WORD_CNT_W-1:0] left_ff, left_in;
   logic [31:0]           addr_ff, addr_in;
   logic [STREAM_W-1:0]   set_ff, set_in;
   logic [STREAM_W-1:0]   val_ff, val_in;
   logic [31:0]           data_ff, mask_ff, oaddr_ff;
   logic                  last_ff;

   logic [2:0]            lg;
   logic                  transparent;
   logic                  emit;
   logic [5:0]            shift_amt;
   logic [REP_W-1:0]      valid_row;
   logic [31:0]           lane_set, lane_val;
   logic [31:0]           word_data, word_mask;

   assign lg          = sat_lg(cfg.pixel_size_log2);
   assign transparent = cfg.text_attributes[TRANSPARENT_BIT];
   assign q_pop       = !active_ff && !q_empty;
   assign emit        = active_ff && (!out_valid_ff || rsp_pop);
   assign shift_amt   = 6'd32 >> lg;

   always_comb begin
      for (int i = 0; i < REP_W; i++) begin
         valid_row[REP_W-1-i] = NPIX_W'(i) < q_desc.npix;
      end
   end

   // Slot s of the current word sits at the top of the stream.
   for (genvar s = 0; s < 32; s++) begin : g_lane
      assign lane_set[s] = set_ff[STREAM_W-1-s];
      assign lane_val[s] = val_ff[STREAM_W-1-s];
   end

   // Bit j counts from the word's most significant end.
   for (genvar j = 0; j < 32; j++) begin : g_bit
      localparam int SLOT [6] = '{j, j >> 1, j >> 2, j >> 3, j >> 4, j >> 5};
      localparam int CB   [6] = '{0, 1 - (j & 1), 3 - (j & 3), 7 - (j & 7),
                                  15 - (j & 15), 31 - (j & 31)};
      logic pset, pval, fg_bit, bg_bit;
      always_comb begin
         pset   = 1'b0;
         pval   = 1'b0;
         fg_bit = 1'b0;
         bg_bit = 1'b0;
         for (int l = 0; l < 6; l++) begin
            if (lg == 3'(l)) begin
               pset   = lane_set[SLOT[l]];
               pval   = lane_val[SLOT[l]];
               fg_bit = cfg.foreground_color[CB[l]];
               bg_bit = cfg.background_color[CB[l]];
            end
         end
         word_mask[31-j] = pval && (pset || !transparent);
         word_data[31-j] = word_mask[31-j] && (pset ? fg_bit : bg_bit);
      end
   end

   always_comb begin
      active_in    = active_ff;
      out_valid_in = out_valid_ff;
      left_in      = left_ff;
      addr_in      = addr_ff;
      set_in       = set_ff;
      val_in       = val_ff;
      if (out_valid_ff && rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (q_pop) begin
         active_in = 1'b1;
         left_in   = q_desc.word_count;
         addr_in   = q_desc.base;
         set_in    = {q_desc.rep, 32'b0} >> q_desc.off_pix;
         val_in    = {valid_row, 32'b0} >> q_desc.off_pix;
      end else if (emit) begin
         out_valid_in = 1'b1;
         left_in      = left_ff - 1'b1;
         addr_in      = addr_ff + 32'd4;
         set_in       = set_ff << shift_amt;
         val_in       = val_ff << shift_amt;
         if (left_ff == WORD_CNT_W'(1)) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      addr_ff <= addr_in;
      set_ff  <= set_in;
      val_ff  <= val_in;
      if (emit) begin
         oaddr_ff <= addr_ff;
         data_ff  <= word_data;
         mask_ff  <= word_mask;
         last_ff  <= (left_ff == WORD_CNT_W'(1));
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_word_address = oaddr_ff;
   assign rsp_word_data    = data_ff;
   assign rsp_bit_mask     = mask_ff;
   assign rsp_last_word    = last_ff;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the glyph row pixel packer.
// ----------------------------------------------------------------------------
// Glyph row transactions go in through the push/full side. A predictor with
// its own copy of the registers works out the word writes of each accepted
// row and queues them. Every popped word transaction is then compared, field
// by field, with the oldest queued write. Directed rows cover the attribute
// rules, every pixel size and the unmapped register indexes. Random rows
// then run under several register settings, the extremes among them, while
// both sides idle and stall at random, but for one phase with no idling.
// ----------------------------------------------------------------------------

module tb_top;
   import grpp_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_PHASES  = 7;
   localparam int ROWS_PER_PHASE = 23;

   // Indexes past the register list; writes to them must change nothing.
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   // Text attribute field values
   localparam logic [6:0] TA_NONE        = 7'd0;
   localparam logic [6:0] TA_BOLD        = 7'd1 << BOLD_BIT;
   localparam logic [6:0] TA_INVERSE     = 7'd1 << INVERSE_BIT;
   localparam logic [6:0] TA_UNDERLINE   = 7'd1 << UNDERLINE_BIT;
   localparam logic [6:0] TA_STRIKE      = 7'd1 << STRIKE_BIT;
   localparam logic [6:0] TA_TRANSPARENT = 7'd1 << TRANSPARENT_BIT;
   localparam logic [6:0] TA_HSCALE_X2   = 7'd1 << HSCALE_LSB;
   localparam logic [6:0] TA_HSCALE_X4   = 7'd3 << HSCALE_LSB;
   localparam logic [6:0] TA_ALL         = 7'h7F;

   typedef struct packed {
      logic [31:0] word_address;
      logic [31:0] word_data;
      logic [31:0] bit_mask;
      logic        last_word;
   } word_write_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        req_push  = 1'b0;
   logic        req_full;
   logic [7:0]  req_glyph_bits = '0;
   logic [3:0]  req_glyph_row  = '0;
   logic [11:0] req_x_pixel    = '0;
   logic [11:0] req_y_line     = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_word_address;
   logic [31:0] rsp_word_data;
   logic [31:0] rsp_bit_mask;
   logic        rsp_last_word;

   // Word writes predicted for accepted rows, oldest first
   word_write_type pending_writes[$];
   word_write_type oldest_write;
   // Register contents as the predictor sees them
   cfg_type     shadow_cfg = '0;
   int          fail_count = 0;
   // Set to run a stretch with no idling on either side
   bit          quiet      = 1'b0;
   int          pop_hold   = 0;
   int          pop_gap;

   glyph_row_pixel_packer uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_glyph_bits   (req_glyph_bits),
      .req_glyph_row    (req_glyph_row),
      .req_x_pixel      (req_x_pixel),
      .req_y_line       (req_y_line),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_word_address (rsp_word_address),
      .rsp_word_data    (rsp_word_data),
      .rsp_bit_mask     (rsp_bit_mask),
      .rsp_last_word    (rsp_last_word)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 50)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Work out the word writes of one glyph row and queue them.
   function automatic void pack_row(input logic [7:0] bits, input logic [3:0] row,
                                    input logic [11:0] x, input logic [11:0] y);
      logic [2:0]  lg;
      logic [6:0]  attr;
      logic [31:0] pmask, fg, bg, xbits, base;
      logic [7:0]  shaped;
      logic [31:0] data [MAX_WORDS];
      logic [31:0] mask [MAX_WORDS];
      int unsigned bpp, hscale, off, npix, nwords, col, bitpos, w, s, i, k;
      bit          fill;
      word_write_type ww;

      attr   = shadow_cfg.text_attributes;
      // Pixel size codes above 32 bpp saturate to 32 bpp.
      lg     = (shadow_cfg.pixel_size_log2 > 3'd5) ? 3'd5 : shadow_cfg.pixel_size_log2;
      bpp    = 1 << lg;
      pmask  = (bpp == 32) ? 32'hFFFF_FFFF : (32'd1 << bpp) - 32'd1;
      // Clip colors to one pixel so they never spill into a neighbor.
      fg     = shadow_cfg.foreground_color & pmask;
      bg     = shadow_cfg.background_color & pmask;
      hscale = attr[HSCALE_LSB +: 2] + 1;

      // Underline and strike rows fill solid; bold smears one pixel right.
      fill = (attr[UNDERLINE_BIT] && row == UNDERLINE_ROW) ||
             (attr[STRIKE_BIT] && row == STRIKE_ROW);
      if (fill) begin
         shaped = '1;
      end else begin
         shaped = bits;
         if (attr[BOLD_BIT])
            shaped = shaped | (shaped >> 1);
      end
      if (attr[INVERSE_BIT])
         shaped = ~shaped;

      xbits  = {20'd0, x} << lg;
      off    = 32'(xbits[4:0]);
      base   = shadow_cfg.frame_base + 32'(shadow_cfg.line_pitch) * 32'(y) +
               ((xbits >> 5) << 2);
      npix   = GLYPH_WIDTH * hscale;
      nwords = (off + npix * bpp + 31) >> 5;
      if (nwords > MAX_WORDS)
         nwords = MAX_WORDS;

      for (k = 0; k < MAX_WORDS; k++) begin
         data[k] = '0;
         mask[k] = '0;
      end
      for (i = 0; i < npix; i++) begin
         col    = i / hscale;
         bitpos = off + i * bpp;
         w      = bitpos >> 5;
         s      = 32 - (bitpos & 31) - bpp;
         if (w < nwords) begin
            if (shaped[GLYPH_WIDTH - 1 - col]) begin
               mask[w] |= pmask << s;
               data[w] |= fg << s;
            end else if (!attr[TRANSPARENT_BIT]) begin
               mask[w] |= pmask << s;
               data[w] |= bg << s;
            end
         end
      end

      for (k = 0; k < nwords; k++) begin
         ww.word_address = base + (k << 2);
         ww.word_data    = data[k];
         ww.bit_mask     = mask[k];
         ww.last_word    = (k + 1 == nwords);
         pending_writes.push_back(ww);
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Result side: hold pop high, drop it for a random stall after a transaction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold <= 0;
      end else if (pop_hold > 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else begin
         pop_gap = (rsp_pop && !rsp_empty) ? idle_length() : 0;
         if (pop_gap > 0) begin
            rsp_pop  <= 1'b0;
            pop_hold <= pop_gap - 1;
         end else begin
            rsp_pop  <= 1'b1;
         end
      end
   end

   // Compare every accepted word transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected word write, expected none actual %h %h %h %b",
                     $time, rsp_word_address, rsp_word_data, rsp_bit_mask, rsp_last_word);
            fail_count++;
         end else begin
            oldest_write = pending_writes.pop_front();
            check_field("word_address", oldest_write.word_address, rsp_word_address);
            check_field("word_data", oldest_write.word_data, rsp_word_data);
            check_field("bit_mask", oldest_write.bit_mask, rsp_bit_mask);
            check_field("last_word", 32'(oldest_write.last_word), 32'(rsp_last_word));
         end
      end
   end

   // Offer one row, wait until it is taken, predict it, then idle at random.
   task automatic send_row(input logic [7:0] bits, input logic [3:0] row,
                           input logic [11:0] x, input logic [11:0] y);
      int gap;
      req_push       <= 1'b1;
      req_glyph_bits <= bits;
      req_glyph_row  <= row;
      req_x_pixel    <= x;
      req_y_line     <= y;
      do @(posedge clock); while (req_full);
      pack_row(bits, row, x, y);
      gap = idle_length();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Random row; a good share lands on the underline and strike rows.
   task automatic send_random_row();
      logic [3:0] row;
      if ($urandom_range(0, 3) == 0)
         row = $urandom_range(0, 1) ? 4'(UNDERLINE_ROW) : 4'(STRIKE_ROW);
      else
         row = 4'($urandom_range(0, 15));
      send_row(8'($urandom_range(0, 255)), row, 12'($urandom_range(0, 4095)),
               12'($urandom_range(0, 4095)));
   endtask

   // Stop offering rows and wait until every predicted write has come back.
   task automatic wait_drain();
      req_push <= 1'b0;
      while (pending_writes.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_reg(input logic [2:0] index, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_PIXEL_SIZE_LOG2: shadow_cfg.pixel_size_log2  = value[2:0];
         CSR_FOREGROUND:      shadow_cfg.foreground_color = value;
         CSR_BACKGROUND:      shadow_cfg.background_color = value;
         CSR_LINE_PITCH:      shadow_cfg.line_pitch       = value[15:0];
         CSR_FRAME_BASE:      shadow_cfg.frame_base       = value;
         CSR_TEXT_ATTR:       shadow_cfg.text_attributes  = value[6:0];
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [2:0] lg, input logic [31:0] fg,
                              input logic [31:0] bg, input logic [15:0] pitch,
                              input logic [31:0] base, input logic [6:0] attr);
      set_reg(CSR_PIXEL_SIZE_LOG2, {29'd0, lg});
      set_reg(CSR_FOREGROUND, fg);
      set_reg(CSR_BACKGROUND, bg);
      set_reg(CSR_LINE_PITCH, {16'd0, pitch});
      set_reg(CSR_FRAME_BASE, base);
      set_reg(CSR_TEXT_ATTR, {25'd0, attr});
      csr_write <= 1'b0;
   endtask

   // Change only the text attributes, once the block has gone idle.
   task automatic switch_attr(input logic [6:0] attr);
      wait_drain();
      set_reg(CSR_TEXT_ATTR, {25'd0, attr});
      csr_write <= 1'b0;
   endtask

   // Registers at their reset values: 1 bpp, black on black, no offset.
   task automatic test_reset_defaults();
      send_row(8'hFF, 4'd0, 12'd0, 12'd0);
      send_row(8'h00, 4'hF, 12'hFFF, 12'hFFF);
      send_row(8'hA5, 4'd3, 12'd31, 12'd1);
      wait_drain();
   endtask

   // One attribute rule at a time, then all of them together.
   task automatic test_attributes();
      load_config(3'd2, 32'hFFFF_FFF5, 32'h0000_000A, 16'd320, 32'h1000_0000, TA_BOLD);
      send_row(8'h81, 4'd2, 12'd5, 12'd10);
      switch_attr(TA_INVERSE);
      send_row(8'h3C, 4'd2, 12'd5, 12'd10);
      switch_attr(TA_UNDERLINE);
      send_row(8'h00, 4'(UNDERLINE_ROW), 12'd9, 12'd11);
      send_row(8'h00, 4'(STRIKE_ROW), 12'd9, 12'd11);
      switch_attr(TA_STRIKE | TA_INVERSE);
      send_row(8'h00, 4'(STRIKE_ROW), 12'd1, 12'd12);
      send_row(8'h00, 4'(UNDERLINE_ROW), 12'd1, 12'd12);
      // A blank row in transparent mode writes nothing: mask all zero.
      switch_attr(TA_TRANSPARENT);
      send_row(8'h00, 4'd1, 12'd3, 12'd13);
      send_row(8'hF0, 4'd1, 12'd3, 12'd13);
      switch_attr(TA_ALL);
      send_row(8'h42, 4'd5, 12'd2, 12'd14);
      wait_drain();
   endtask

   // Every pixel size code, with the oversized codes and wide colors.
   task automatic test_pixel_sizes();
      logic [2:0] lg;
      for (int code = 0; code < 8; code++) begin
         lg = 3'(code);
         wait_drain();
         load_config(lg, 32'hDEAD_BEEF, 32'h1234_5679, 16'hFFFF, 32'hFFFF_FFF0,
                     (lg == 3'd5) ? TA_HSCALE_X4 : TA_HSCALE_X2);
         send_row(8'hC3, 4'd4, 12'hFFF, 12'hFFF);
      end
      wait_drain();
   endtask

   // Writes past the register list must leave the settings alone.
   task automatic test_unmapped_index();
      wait_drain();
      set_reg(CSR_SPARE_LO, 32'hFFFF_FFFF);
      set_reg(CSR_SPARE_HI, 32'hFFFF_FFFF);
      csr_write <= 1'b0;
      send_row(8'h5A, 4'd6, 12'd100, 12'd200);
      wait_drain();
   endtask

   // Random rows under one setting per phase: all-max, all-min, then random.
   task automatic test_random_rows();
      logic [2:0] lg;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drain();
         quiet = (phase == 2);
         if (phase == 0) begin
            load_config(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, TA_ALL);
         end else if (phase == 1) begin
            load_config(3'd0, 32'd0, 32'd0, 16'd0, 32'd0, TA_NONE);
         end else begin
            // Keep most phases at small pixel sizes so rows stay short.
            lg = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 3)) :
                                              3'($urandom_range(4, 7));
            load_config(lg, $urandom, $urandom, 16'($urandom_range(0, 65535)), $urandom,
                        7'($urandom_range(0, 127)));
         end
         for (int n = 0; n < ROWS_PER_PHASE; n++) begin
            // Hold off the sender once until the block has fully drained.
            if (phase == 3 && n == ROWS_PER_PHASE / 2)
               wait_drain();
            send_random_row();
         end
      end
      quiet = 1'b0;
      wait_drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_attributes();
      test_pixel_sizes();
      test_unmapped_index();
      test_random_rows();

      // Let any stray transaction surface before the verdict.
      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("%0t: timeout, %0d word writes still pending", $time, pending_writes.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
